/* design/kcac_pkg.sv */
// Package for the keypad code alarm controller: widths, reset values, register indexes,
// the mode encoding and the structs passed between the debouncer, the core and the top level.
// No dependencies; every other design file refers to it by scoped names.
package kcac_pkg;

  localparam int HISTORY_DEPTH_DEF = 8;

  localparam int BTN_W       = 3;
  localparam int ARM_DELAY_W = 15;
  localparam int BLINK_W     = 8;
  localparam int CODE_W      = 9;
  localparam int STATE_W     = 3;
  localparam int MOTOR_W     = 2;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 15;

  localparam logic [ARM_DELAY_W-1:0] ARM_DELAY_RST   = ARM_DELAY_W'(1000);
  localparam logic [BLINK_W-1:0]     BLINK_RST       = BLINK_W'(25);
  localparam logic [CODE_W-1:0]      DISARM_CODE_RST = CODE_W'(98);
  localparam logic [CODE_W-1:0]      ARM_CODE_RST    = CODE_W'(266);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_ARM_DELAY   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BLINK       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISARM_CODE = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARM_CODE    = 2'd3;

  // Bit positions in the LED/buzzer level register.
  localparam int LED_GREEN  = 0;
  localparam int LED_RED    = 1;
  localparam int LED_BUZZER = 2;

  // Lower half is disarmed, upper half is armed.
  typedef enum logic [STATE_W-1:0] {
    ST_DISARMED  = 3'd0,
    ST_DIS1      = 3'd1,
    ST_DIS2      = 3'd2,
    ST_ARMING    = 3'd3,
    ST_ARMED     = 3'd4,
    ST_ARM1      = 3'd5,
    ST_ARM2      = 3'd6,
    ST_DISARMING = 3'd7
  } mode_t;

  typedef enum logic [MOTOR_W-1:0] {
    MOTOR_NONE     = 2'd0,
    MOTOR_BACKWARD = 2'd1,
    MOTOR_FORWARD  = 2'd2
  } motor_t;

  typedef struct packed {
    logic [ARM_DELAY_W-1:0] arm_delay_ticks;
    logic [BLINK_W-1:0]     blink_period;
    logic [CODE_W-1:0]      disarm_code;
    logic [CODE_W-1:0]      arm_code;
  } cfg_t;

  typedef struct packed {
    logic [BTN_W-1:0] pressed;
    logic [BTN_W-1:0] released;
  } edges_t;

  typedef struct packed {
    logic [STATE_W-1:0] alarm_state;
    logic               tripped;
    logic               green_led;
    logic               red_led;
    logic               buzzer;
    logic [MOTOR_W-1:0] motor_cmd;
  } core_out_t;

  // Button mask for one step of a three-step code; the first step sits in the low bits.
  function automatic logic [BTN_W-1:0] code_step(input logic [CODE_W-1:0] code,
                                                 input logic [1:0] step);
    logic [BTN_W-1:0] mask;
    case (step)
      2'd0:    mask = code[BTN_W-1:0];
      2'd1:    mask = code[2*BTN_W-1:BTN_W];
      2'd2:    mask = code[3*BTN_W-1:2*BTN_W];
      default: mask = '0;
    endcase
    return mask;
  endfunction

endpackage

/* design/kcac_if.sv */
// Valid/ready channel interfaces for the keypad code alarm controller.
// Depends on kcac_pkg for the field widths.
interface kcac_in_if;
  logic                      valid;
  logic                      ready;
  logic [kcac_pkg::BTN_W-1:0] button_sample;

  modport source (output valid, output button_sample, input ready);
  modport sink (input valid, input button_sample, output ready);
endinterface

interface kcac_out_if;
  logic                        valid;
  logic                        ready;
  logic [kcac_pkg::STATE_W-1:0] alarm_state;
  logic                        tripped;
  logic                        green_led;
  logic                        red_led;
  logic                        buzzer;
  logic [kcac_pkg::MOTOR_W-1:0] motor_cmd;
  logic [kcac_pkg::BTN_W-1:0]   pressed_edges;
  logic [kcac_pkg::BTN_W-1:0]   released_edges;

  modport source (output valid, output alarm_state, output tripped, output green_led,
                  output red_led, output buzzer, output motor_cmd, output pressed_edges,
                  output released_edges, input ready);
  modport sink (input valid, input alarm_state, input tripped, input green_led,
                input red_led, input buzzer, input motor_cmd, input pressed_edges,
                input released_edges, output ready);
endinterface

/* design/kcac_debounce.sv */
// Button debouncer: a shift line of past samples and the debounced levels with edge detection.
// Depends on kcac_pkg.
module kcac_debounce #(
  parameter int HISTORY_DEPTH = kcac_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  logic [kcac_pkg::BTN_W-1:0] sample,
  output kcac_pkg::edges_t           edges
);

  // The window is the new sample plus the previous HISTORY_DEPTH-1 samples.
  localparam int PAST = HISTORY_DEPTH - 1;

  logic [kcac_pkg::BTN_W-1:0] hist_r [PAST];
  logic [kcac_pkg::BTN_W-1:0] level_r;
  logic [kcac_pkg::BTN_W-1:0] level_nxt;
  logic [kcac_pkg::BTN_W-1:0] all_high;
  logic [kcac_pkg::BTN_W-1:0] any_high;

  always_comb begin
    all_high = sample;
    any_high = sample;
    for (int i = 0; i < PAST; i++) begin
      all_high = all_high & hist_r[i];
      any_high = any_high | hist_r[i];
    end
    edges.released = ~level_r & all_high;
    edges.pressed  = level_r & ~any_high;
    level_nxt      = all_high | (level_r & any_high);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      for (int i = 0; i < PAST; i++) begin
        hist_r[i] <= '0;
      end
    end else if (advance) begin
      level_r   <= level_nxt;
      hist_r[0] <= sample;
      for (int i = 1; i < PAST; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // A button cannot be reported pressed and released on the same tick.
  a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    (edges.pressed & edges.released) == '0)
    else $error("press and release edge on the same button");

  // A release edge means the whole window was high, so the level is high afterwards.
  a_release_sets_level: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && edges.released != '0) |=> ((level_r & $past(edges.released))
                                           == $past(edges.released)))
    else $error("release edge did not raise the debounced level");

  // Levels change only on an accepted sample.
  a_level_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(level_r))
    else $error("debounced level changed without a sample");

endmodule

/* design/kcac_core.sv */
// Code-entry state machine, arm countdown and LED/buzzer/motor logic of the alarm.
// Depends on kcac_pkg.
module kcac_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  kcac_pkg::cfg_t             cfg,
  input  logic [kcac_pkg::BTN_W-1:0] pressed,
  output kcac_pkg::core_out_t        result
);

  kcac_pkg::mode_t mode_r, mode_nxt, mode_a;
  logic            tripped_r, tripped_nxt, trip_a;
  logic [kcac_pkg::ARM_DELAY_W-1:0] cnt_r, cnt_nxt, cnt_a;
  logic [kcac_pkg::BLINK_W-1:0]     blink_r, blink_nxt;
  logic [kcac_pkg::BTN_W-1:0]       led_r, led_nxt;
  kcac_pkg::motor_t                 motor;
  logic                             dis_hit;
  logic                             arm_hit;

  always_comb begin
    // Step index is the low two bits of the mode in both halves.
    dis_hit = |(pressed & kcac_pkg::code_step(cfg.disarm_code, mode_r[1:0]));
    arm_hit = |(pressed & kcac_pkg::code_step(cfg.arm_code, mode_r[1:0]));

    mode_a = mode_r;
    trip_a = tripped_r;
    cnt_a  = cnt_r;
    if (pressed != '0) begin
      unique case (mode_r)
        kcac_pkg::ST_DISARMED: begin
          if (dis_hit) mode_a = kcac_pkg::ST_DIS1;
        end
        kcac_pkg::ST_DIS1: begin
          mode_a = dis_hit ? kcac_pkg::ST_DIS2 : kcac_pkg::ST_DISARMED;
        end
        kcac_pkg::ST_DIS2: begin
          if (dis_hit) begin
            mode_a = kcac_pkg::ST_ARMING;
            cnt_a  = cfg.arm_delay_ticks;
          end else begin
            mode_a = kcac_pkg::ST_DISARMED;
          end
        end
        kcac_pkg::ST_ARMED: begin
          if (arm_hit) mode_a = kcac_pkg::ST_ARM1;
          else trip_a = 1'b1;
        end
        kcac_pkg::ST_ARM1, kcac_pkg::ST_ARM2: begin
          if (arm_hit) begin
            mode_a = (mode_r == kcac_pkg::ST_ARM1) ? kcac_pkg::ST_ARM2
                                                   : kcac_pkg::ST_DISARMING;
            if (mode_r == kcac_pkg::ST_ARM2) cnt_a = cfg.arm_delay_ticks;
          end else begin
            mode_a = kcac_pkg::ST_ARMED;
            trip_a = 1'b1;
          end
        end
        // Presses are ignored while the countdown runs or the disarm completes.
        kcac_pkg::ST_ARMING, kcac_pkg::ST_DISARMING: begin
          mode_a = mode_r;
        end
        default: mode_a = mode_r;
      endcase
    end

    mode_nxt    = mode_a;
    tripped_nxt = trip_a;
    cnt_nxt     = cnt_a;
    motor       = kcac_pkg::MOTOR_NONE;
    if (mode_a == kcac_pkg::ST_ARMING) begin
      if (cnt_a <= kcac_pkg::ARM_DELAY_W'(1)) begin
        cnt_nxt  = '0;
        mode_nxt = kcac_pkg::ST_ARMED;
        motor    = kcac_pkg::MOTOR_BACKWARD;
      end else begin
        cnt_nxt = cnt_a - kcac_pkg::ARM_DELAY_W'(1);
      end
    end else if (mode_a == kcac_pkg::ST_DISARMING) begin
      tripped_nxt = 1'b0;
      mode_nxt    = kcac_pkg::ST_DISARMED;
      motor       = kcac_pkg::MOTOR_FORWARD;
    end

    blink_nxt = blink_r;
    led_nxt   = '0;
    if (!mode_nxt[2]) begin
      led_nxt[kcac_pkg::LED_GREEN] = 1'b1;
      blink_nxt = '0;
    end else if (!tripped_nxt) begin
      led_nxt[kcac_pkg::LED_RED] = 1'b1;
    end else begin
      led_nxt[kcac_pkg::LED_BUZZER] = 1'b1;
      led_nxt[kcac_pkg::LED_RED]    = led_r[kcac_pkg::LED_RED];
      if (blink_r >= cfg.blink_period) begin
        led_nxt[kcac_pkg::LED_RED] = ~led_r[kcac_pkg::LED_RED];
        blink_nxt = '0;
      end else begin
        blink_nxt = blink_r + kcac_pkg::BLINK_W'(1);
      end
    end

    result.alarm_state = mode_nxt;
    result.tripped     = tripped_nxt;
    result.green_led   = led_nxt[kcac_pkg::LED_GREEN];
    result.red_led     = led_nxt[kcac_pkg::LED_RED];
    result.buzzer      = led_nxt[kcac_pkg::LED_BUZZER];
    result.motor_cmd   = motor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= kcac_pkg::ST_DISARMED;
      tripped_r <= 1'b0;
      cnt_r     <= kcac_pkg::ARM_DELAY_RST;
      blink_r   <= '0;
      led_r     <= '0;
    end else if (advance) begin
      mode_r    <= mode_nxt;
      tripped_r <= tripped_nxt;
      cnt_r     <= cnt_nxt;
      blink_r   <= blink_nxt;
      led_r     <= led_nxt;
    end
  end

  // The disarm-complete state resolves within its own tick and is never held.
  a_no_hold_disarming: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != kcac_pkg::ST_DISARMING)
    else $error("disarm-complete state was stored");

  // The tripped flag only exists in the armed half.
  a_trip_armed: assert property (@(posedge clk) disable iff (!rst_n)
    tripped_r |-> mode_r[2])
    else $error("tripped while disarmed");

  // The buzzer sounds only when tripped.
  a_buzzer_trip: assert property (@(posedge clk) disable iff (!rst_n)
    led_r[kcac_pkg::LED_BUZZER] |-> tripped_r)
    else $error("buzzer on without trip");

endmodule

/* design/keypad_code_alarm_controller_unit.sv */
// Top level of the keypad code alarm controller: configuration registers, debouncer, core
// and the result register. Depends on kcac_pkg, kcac_if, kcac_debounce and kcac_core.
//
// Usage. The in_req channel carries one request per 10 ms tick: button_sample holds the raw
// levels of the three buttons, low meaning pressed. Every accepted request produces exactly one
// result on out_res: the alarm state after the tick, the tripped flag, the green, red and
// buzzer drives, a one-tick motor command and the debounced press and release edges.
// Configuration is written through cfg_we/cfg_index/cfg_wdata, one register per edge with cfg_we
// high. The user must write only while no request is in flight; the block does not enforce it.
//
// Latency and throughput. The debounce window, the code machine, the countdown and the LED logic
// all evaluate combinationally between the incoming request and the result register, so a result
// is valid the cycle after its request is accepted, and one request is taken every cycle while
// out_res.ready stays high. The single result register is what paces the block: in_req.ready is
// high whenever that register is empty or being emptied in the same cycle.
//
// Reset. rst_n is synchronous and active low. It clears the sample history and debounced
// levels, returns the machine to the disarmed idle state, reloads the countdown with 1000 and
// restores the register defaults (arm delay 1000, blink period 25, codes 98 and 266).
//
// Stalls. When out_res.ready is low with a result waiting, the result holds and in_req.ready
// drops, so no request is taken until the receiver frees the register.
module keypad_code_alarm_controller_unit #(
  parameter int HISTORY_DEPTH = kcac_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  kcac_in_if.sink                          in_req,
  kcac_out_if.source                       out_res,
  input  logic                             cfg_we,
  input  logic [kcac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kcac_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  kcac_pkg::cfg_t      cfg_r;
  kcac_pkg::edges_t    edges;
  kcac_pkg::core_out_t core_res;
  kcac_pkg::edges_t    edges_r;
  kcac_pkg::core_out_t core_res_r;
  logic                out_valid_r;
  logic                accept;

  // A request is taken when the result register is empty or drains this cycle.
  assign in_req.ready = !out_valid_r || out_res.ready;
  assign accept       = in_req.valid && in_req.ready;

  // Configuration registers; each write is truncated to the register's width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.arm_delay_ticks <= kcac_pkg::ARM_DELAY_RST;
      cfg_r.blink_period    <= kcac_pkg::BLINK_RST;
      cfg_r.disarm_code     <= kcac_pkg::DISARM_CODE_RST;
      cfg_r.arm_code        <= kcac_pkg::ARM_CODE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcac_pkg::CFG_ARM_DELAY:   cfg_r.arm_delay_ticks <= cfg_wdata;
        kcac_pkg::CFG_BLINK:       cfg_r.blink_period <= cfg_wdata[kcac_pkg::BLINK_W-1:0];
        kcac_pkg::CFG_DISARM_CODE: cfg_r.disarm_code <= cfg_wdata[kcac_pkg::CODE_W-1:0];
        kcac_pkg::CFG_ARM_CODE:    cfg_r.arm_code <= cfg_wdata[kcac_pkg::CODE_W-1:0];
        default:                   cfg_r <= cfg_r;
      endcase
    end
  end

  kcac_debounce #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_debounce (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .sample  (in_req.button_sample),
    .edges   (edges)
  );

  kcac_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (accept),
    .cfg     (cfg_r),
    .pressed (edges.pressed),
    .result  (core_res)
  );

  // Result register: control bit under reset, payload loaded on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      edges_r    <= edges;
      core_res_r <= core_res;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.alarm_state    = core_res_r.alarm_state;
  assign out_res.tripped        = core_res_r.tripped;
  assign out_res.green_led      = core_res_r.green_led;
  assign out_res.red_led        = core_res_r.red_led;
  assign out_res.buzzer         = core_res_r.buzzer;
  assign out_res.motor_cmd      = core_res_r.motor_cmd;
  assign out_res.pressed_edges  = edges_r.pressed;
  assign out_res.released_edges = edges_r.released;

  // Every accepted request leaves a result in the register on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request produced no result");

  // Green shows exactly while the reported state is in the disarmed half.
  a_green_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (core_res_r.green_led == !core_res_r.alarm_state[2]))
    else $error("green LED disagrees with alarm state");

  // A motor command is always one of the defined codes and never comes with a tripped flag
  // on a forward turn.
  a_motor_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((core_res_r.motor_cmd == kcac_pkg::MOTOR_NONE ||
                      core_res_r.motor_cmd == kcac_pkg::MOTOR_BACKWARD ||
                      core_res_r.motor_cmd == kcac_pkg::MOTOR_FORWARD) &&
                     !(core_res_r.motor_cmd == kcac_pkg::MOTOR_FORWARD &&
                       core_res_r.tripped)))
    else $error("bad motor command");

endmodule

/* bench/keypad_code_alarm_controller_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for keypad_code_alarm_controller_unit: sends button ticks, predicts each
// tick result with a local model of the debouncer and code machine, and checks every field.
// Depends on kcac_pkg, kcac_if and the design files of the block.
module keypad_code_alarm_controller_unit_tb;

  localparam int BTN_W       = kcac_pkg::BTN_W;
  localparam int ARM_DELAY_W = kcac_pkg::ARM_DELAY_W;
  localparam int BLINK_W     = kcac_pkg::BLINK_W;
  localparam int CODE_W      = kcac_pkg::CODE_W;
  localparam int STATE_W     = kcac_pkg::STATE_W;
  localparam int MOTOR_W     = kcac_pkg::MOTOR_W;
  localparam int CFG_INDEX_W = kcac_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = kcac_pkg::CFG_DATA_W;

  localparam int HIST_DEPTH    = kcac_pkg::HISTORY_DEPTH_DEF;
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int RANDOM_TICKS  = 160;
  localparam int RANDOM_PHASES = 4;

  // Button masks: a set bit means that button is pressed (its raw level is low).
  localparam logic [BTN_W-1:0] BTN_A  = BTN_W'(1);
  localparam logic [BTN_W-1:0] BTN_B  = BTN_W'(2);
  localparam logic [BTN_W-1:0] BTN_C  = BTN_W'(4);
  localparam logic [BTN_W-1:0] ALL_UP = '1;

  localparam logic [BTN_W-1:0] GREEN_ON = BTN_W'(1 << kcac_pkg::LED_GREEN);
  localparam logic [BTN_W-1:0] RED_ON   = BTN_W'(1 << kcac_pkg::LED_RED);
  localparam logic [BTN_W-1:0] BUZZ_ON  = BTN_W'(1 << kcac_pkg::LED_BUZZER);

  localparam logic [CODE_W-1:0] CODE_NONE = '0;
  localparam logic [CODE_W-1:0] CODE_ALL  = '1;

  // One tick result, laid out like the result channel.
  typedef struct packed {
    logic [STATE_W-1:0] alarm_state;
    logic               tripped;
    logic               green_led;
    logic               red_led;
    logic               buzzer;
    logic [MOTOR_W-1:0] motor_cmd;
    logic [BTN_W-1:0]   pressed;
    logic [BTN_W-1:0]   released;
  } tick_result_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  kcac_in_if  in_req ();
  kcac_out_if out_res ();

  keypad_code_alarm_controller_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .out_res   (out_res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies as the block holds them.
  logic [ARM_DELAY_W-1:0] arm_delay_cfg;
  logic [BLINK_W-1:0]     blink_cfg;
  logic [CODE_W-1:0]      disarm_code_cfg;
  logic [CODE_W-1:0]      armed_code_cfg;

  // Predicted internal state of the alarm.
  logic [BTN_W-1:0]   sample_log [HIST_DEPTH];
  int unsigned        log_slot;
  logic [BTN_W-1:0]   btn_level;
  kcac_pkg::mode_t    mode_q;
  logic               trip_q;
  logic [15:0]        countdown_q;
  logic [BLINK_W-1:0] blink_cnt_q;
  logic [BTN_W-1:0]   lamps_q;

  // Results owed by the block, oldest first, one per accepted request.
  tick_result_t results_due [$];

  int unsigned ticks_sent = 0;
  int unsigned mismatches = 0;
  int unsigned stall_left = 0;
  int unsigned cycles     = 0;
  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------------------------
  // Alarm model
  // ---------------------------------------------------------------------------------------------

  function automatic logic [BTN_W-1:0] code_digit(input logic [CODE_W-1:0] code, input int n);
    return code[BTN_W*n +: BTN_W];
  endfunction

  task automatic model_reset();
    arm_delay_cfg   = kcac_pkg::ARM_DELAY_RST;
    blink_cfg       = kcac_pkg::BLINK_RST;
    disarm_code_cfg = kcac_pkg::DISARM_CODE_RST;
    armed_code_cfg  = kcac_pkg::ARM_CODE_RST;
    foreach (sample_log[i]) sample_log[i] = '0;
    log_slot    = 0;
    btn_level   = '0;
    mode_q      = kcac_pkg::ST_DISARMED;
    trip_q      = 1'b0;
    countdown_q = 16'(kcac_pkg::ARM_DELAY_RST);
    blink_cnt_q = '0;
    lamps_q     = '0;
  endtask

  // A debounced press moves the code machine one digit. A digit matches when any pressed
  // button is in that digit's mask, so an empty mask can never match. While the lock is
  // counting down to arm, presses are ignored.
  function automatic void enter_digit(input logic [BTN_W-1:0] hits);
    case (mode_q)
      kcac_pkg::ST_DISARMED: begin
        if (|(hits & code_digit(disarm_code_cfg, 0))) mode_q = kcac_pkg::ST_DIS1;
      end
      kcac_pkg::ST_DIS1: begin
        mode_q = |(hits & code_digit(disarm_code_cfg, 1)) ? kcac_pkg::ST_DIS2
                                                          : kcac_pkg::ST_DISARMED;
      end
      kcac_pkg::ST_DIS2: begin
        if (|(hits & code_digit(disarm_code_cfg, 2))) begin
          mode_q      = kcac_pkg::ST_ARMING;
          countdown_q = 16'(arm_delay_cfg);
        end else begin
          mode_q = kcac_pkg::ST_DISARMED;
        end
      end
      kcac_pkg::ST_ARMED: begin
        if (|(hits & code_digit(armed_code_cfg, 0))) mode_q = kcac_pkg::ST_ARM1;
        else trip_q = 1'b1;
      end
      kcac_pkg::ST_ARM1: begin
        if (|(hits & code_digit(armed_code_cfg, 1))) begin
          mode_q = kcac_pkg::ST_ARM2;
        end else begin
          mode_q = kcac_pkg::ST_ARMED;
          trip_q = 1'b1;
        end
      end
      kcac_pkg::ST_ARM2: begin
        if (|(hits & code_digit(armed_code_cfg, 2))) begin
          mode_q      = kcac_pkg::ST_DISARMING;
          countdown_q = 16'(arm_delay_cfg);
        end else begin
          mode_q = kcac_pkg::ST_ARMED;
          trip_q = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Advances the model by one tick and returns the result the block must produce for it.
  function automatic tick_result_t alarm_tick(input logic [BTN_W-1:0] btns);
    logic [BTN_W-1:0] all_up;
    logic [BTN_W-1:0] any_up;
    logic [BTN_W-1:0] rising;
    logic [BTN_W-1:0] falling;
    logic             red;
    kcac_pkg::motor_t motor;
    tick_result_t     res;
    all_up = ALL_UP;
    any_up = '0;
    motor  = kcac_pkg::MOTOR_NONE;
    sample_log[log_slot] = btns;
    for (int i = 0; i < HIST_DEPTH; i++) begin
      all_up &= sample_log[i];
      any_up |= sample_log[i];
    end
    // A level changes only when the whole history agrees; otherwise it holds.
    rising    = ~btn_level & all_up;
    falling   = btn_level & ~any_up;
    btn_level = all_up | (btn_level & any_up);
    log_slot  = (log_slot + 1) % HIST_DEPTH;

    if (falling != '0) enter_digit(falling);

    // The countdown includes the tick that completed the code; zero behaves like one.
    if (mode_q == kcac_pkg::ST_ARMING) begin
      if (countdown_q <= 16'd1) begin
        countdown_q = '0;
        mode_q      = kcac_pkg::ST_ARMED;
        motor       = kcac_pkg::MOTOR_BACKWARD;
      end else begin
        countdown_q = countdown_q - 16'd1;
      end
    end else if (mode_q == kcac_pkg::ST_DISARMING) begin
      trip_q = 1'b0;
      mode_q = kcac_pkg::ST_DISARMED;
      motor  = kcac_pkg::MOTOR_FORWARD;
    end

    if (mode_q < kcac_pkg::ST_ARMED) begin
      lamps_q     = GREEN_ON;
      blink_cnt_q = '0;
    end else if (!trip_q) begin
      lamps_q = RED_ON;
    end else begin
      red = lamps_q[kcac_pkg::LED_RED];
      if (blink_cnt_q >= blink_cfg) begin
        red         = ~red;
        blink_cnt_q = '0;
      end else begin
        blink_cnt_q = blink_cnt_q + 1'b1;
      end
      lamps_q                    = BUZZ_ON;
      lamps_q[kcac_pkg::LED_RED] = red;
    end

    res.alarm_state = mode_q;
    res.tripped     = trip_q;
    res.green_led   = lamps_q[kcac_pkg::LED_GREEN];
    res.red_led     = lamps_q[kcac_pkg::LED_RED];
    res.buzzer      = lamps_q[kcac_pkg::LED_BUZZER];
    res.motor_cmd   = motor;
    res.pressed     = falling;
    res.released    = rising;
    return res;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // Driving the block
  // ---------------------------------------------------------------------------------------------

  // Sends one tick request and records its predicted result once the block takes it. valid
  // stays high into the next request unless a random gap drops it first.
  task automatic send_tick(input logic [BTN_W-1:0] btns);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_req.valid         <= 1'b1;
    in_req.button_sample <= btns;
    @(posedge clk);
    while (!in_req.ready) @(posedge clk);
    results_due.push_back(alarm_tick(btns));
    ticks_sent++;
  endtask

  task automatic hold(input logic [BTN_W-1:0] btns, input int n);
    repeat (n) send_tick(btns);
  endtask

  // One full press: the buttons go down long enough to debounce, then come back up. With
  // chatter on, the pressed buttons flutter for a few ticks at each transition.
  task automatic press(input logic [BTN_W-1:0] buttons, input bit chatter);
    if (chatter) repeat ($urandom_range(1, 3)) send_tick(~(buttons & BTN_W'($urandom)));
    hold(~buttons, HIST_DEPTH + $urandom_range(0, 1));
    if (chatter) repeat ($urandom_range(1, 3)) send_tick(~(buttons & BTN_W'($urandom)));
    hold(ALL_UP, HIST_DEPTH + $urandom_range(0, 1));
  endtask

  task automatic enter_code(input logic [CODE_W-1:0] code, input bit chatter);
    for (int d = 0; d < 3; d++) press(code_digit(code, d), chatter);
  endtask

  task automatic wait_armed();
    while (mode_q == kcac_pkg::ST_ARMING) send_tick(ALL_UP);
  endtask

  // Any press set that hits the digit; a random set when the digit is empty.
  function automatic logic [BTN_W-1:0] hit_mask(input logic [BTN_W-1:0] digit);
    logic [BTN_W-1:0] pick;
    pick = BTN_W'($urandom_range(1, 7));
    if (digit != '0) begin
      while ((pick & digit) == '0) pick = BTN_W'($urandom_range(1, 7));
    end
    return pick;
  endfunction

  // Lowers valid and waits until every request in flight has produced its result.
  task automatic settle();
    in_req.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      kcac_pkg::CFG_ARM_DELAY:   arm_delay_cfg   = data[ARM_DELAY_W-1:0];
      kcac_pkg::CFG_BLINK:       blink_cfg       = data[BLINK_W-1:0];
      kcac_pkg::CFG_DISARM_CODE: disarm_code_cfg = data[CODE_W-1:0];
      kcac_pkg::CFG_ARM_CODE:    armed_code_cfg  = data[CODE_W-1:0];
      default: begin
      end
    endcase
  endtask

  // Writes all four registers while the block is idle. Bits above a register's width carry
  // random junk that the block has to drop.
  task automatic set_config(input logic [ARM_DELAY_W-1:0] delay,
                            input logic [BLINK_W-1:0] period,
                            input logic [CODE_W-1:0] dis_code,
                            input logic [CODE_W-1:0] armed_code);
    settle();
    write_reg(kcac_pkg::CFG_ARM_DELAY, CFG_DATA_W'(delay));
    write_reg(kcac_pkg::CFG_BLINK, CFG_DATA_W'({$urandom_range(0, 127), period}));
    write_reg(kcac_pkg::CFG_DISARM_CODE, CFG_DATA_W'({$urandom_range(0, 63), dis_code}));
    write_reg(kcac_pkg::CFG_ARM_CODE, CFG_DATA_W'({$urandom_range(0, 63), armed_code}));
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------------------------
  // Receiver side and checking
  // ---------------------------------------------------------------------------------------------

  // The receiver stalls in random bursts while stalls are enabled.
  initial begin
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left != 0) begin
        stall_left--;
        out_res.ready <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 2);
        out_res.ready <= 1'b0;
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input logic [3:0] want,
                                      input logic [3:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (results_due.size() == 0) begin
        mismatches++;
        $display("%0t ns: result with no request pending, expected none, actual state %0d",
                 $time, out_res.alarm_state);
      end else begin
        want = results_due.pop_front();
        check_field("alarm_state", 4'(want.alarm_state), 4'(out_res.alarm_state));
        check_field("tripped", 4'(want.tripped), 4'(out_res.tripped));
        check_field("green_led", 4'(want.green_led), 4'(out_res.green_led));
        check_field("red_led", 4'(want.red_led), 4'(out_res.red_led));
        check_field("buzzer", 4'(want.buzzer), 4'(out_res.buzzer));
        check_field("motor_cmd", 4'(want.motor_cmd), 4'(out_res.motor_cmd));
        check_field("pressed_edges", 4'(want.pressed), 4'(out_res.pressed_edges));
        check_field("released_edges", 4'(want.released), 4'(out_res.released_edges));
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------------

  // Starts on the reset register values: the history starts all low, so the buttons read as
  // held until eight released samples agree. The default code is entered; before its last
  // digit the arm delay is shortened to one so the lock arms on the completing tick. A wrong
  // digit then trips it at the default blink rate, and the default armed code opens it again.
  task automatic test_reset_defaults();
    hold('0, 2);
    hold(ALL_UP, HIST_DEPTH);
    press(code_digit(kcac_pkg::DISARM_CODE_RST, 0), 1'b0);
    press(code_digit(kcac_pkg::DISARM_CODE_RST, 1), 1'b0);
    set_config(ARM_DELAY_W'(1), kcac_pkg::BLINK_RST, kcac_pkg::DISARM_CODE_RST,
               kcac_pkg::ARM_CODE_RST);
    press(code_digit(kcac_pkg::DISARM_CODE_RST, 2), 1'b0);
    wait_armed();
    press(~code_digit(kcac_pkg::ARM_CODE_RST, 0), 1'b0);
    hold(ALL_UP, 30);
    enter_code(kcac_pkg::ARM_CODE_RST, 1'b0);
  endtask

  // Debouncer edges. The disarm code is empty here, so no press moves the code machine.
  task automatic test_debounce_edges();
    set_config(ARM_DELAY_W'(1), BLINK_W'(3), CODE_NONE, {BTN_A, BTN_B, BTN_C});
    // Pulses of one tick and of one tick shorter than the history never make an edge.
    hold(~BTN_B, 1);
    hold(ALL_UP, HIST_DEPTH);
    hold(~BTN_B, HIST_DEPTH - 1);
    hold(ALL_UP, HIST_DEPTH);
    // All three buttons at once give a three-bit press and release.
    press(ALL_UP, 1'b0);
    // Staggered buttons: A falls first, B a few ticks later, both rise together.
    hold(~BTN_A, 4);
    hold(~(BTN_A | BTN_B), HIST_DEPTH);
    hold(ALL_UP, HIST_DEPTH);
    // Chatter holds the debounced levels wherever they are.
    hold(~BTN_C, HIST_DEPTH);
    repeat (12) send_tick(BTN_W'($urandom));
    hold(ALL_UP, HIST_DEPTH);
    press(BTN_C, 1'b1);
  endtask

  // Disarmed half: a wrong first digit keeps progress at zero, a wrong later digit drops it,
  // and a press set matches when any one of its buttons is in the digit's mask.
  task automatic test_disarm_entry();
    set_config(ARM_DELAY_W'(2), '0, {BTN_B | BTN_C, BTN_C, BTN_A | BTN_B},
               {BTN_C, BTN_B, BTN_A});
    press(BTN_C, 1'b0);
    press(BTN_B, 1'b0);
    press(BTN_A, 1'b0);
    press(BTN_A, 1'b0);
    press(BTN_C, 1'b0);
    press(BTN_A, 1'b0);
    press(BTN_A | BTN_C, 1'b1);
    press(BTN_A | BTN_C, 1'b1);
    press(ALL_UP, 1'b1);
    wait_armed();
  endtask

  // Armed half with a blink period of zero: each wrong digit trips the alarm and drops back to
  // the first digit, and the full code disarms at once and clears the trip.
  task automatic test_armed_entry();
    press(BTN_B, 1'b0);
    press(BTN_A, 1'b0);
    press(BTN_A, 1'b0);
    press(BTN_B, 1'b0);
    press(BTN_B, 1'b0);
    press(BTN_A, 1'b0);
    press(BTN_B | BTN_C, 1'b0);
    press(BTN_C, 1'b1);
  endtask

  // Empty code masks never match. Presses during the arm countdown are ignored, and a trip
  // runs long enough to see the red LED toggle a few times.
  task automatic test_zero_codes();
    set_config(ARM_DELAY_W'(40), BLINK_W'(20), CODE_NONE, CODE_NONE);
    press(ALL_UP, 1'b0);
    set_config(ARM_DELAY_W'(40), BLINK_W'(20), {BTN_A, BTN_A, BTN_A}, CODE_NONE);
    enter_code({BTN_A, BTN_A, BTN_A}, 1'b0);
    press(ALL_UP, 1'b0);
    wait_armed();
    press(ALL_UP, 1'b0);
    hold(ALL_UP, 50);
    set_config(ARM_DELAY_W'(40), BLINK_W'(20), {BTN_A, BTN_A, BTN_A}, {BTN_C, BTN_C, BTN_C});
    enter_code({BTN_C, BTN_C, BTN_C}, 1'b0);
  endtask

  // An arm delay of zero arms on the tick that completes the code, as a delay of one does.
  task automatic test_arm_delay_extremes();
    set_config('0, BLINK_W'(1), CODE_ALL, CODE_ALL);
    for (int d = 0; d < 3; d++) press(hit_mask(ALL_UP), 1'b0);
    for (int d = 0; d < 3; d++) press(hit_mask(ALL_UP), 1'b0);
  endtask

  function automatic logic [CODE_W-1:0] random_code();
    logic [CODE_W-1:0] code;
    for (int d = 0; d < 3; d++)
      code[BTN_W*d +: BTN_W] = ($urandom_range(0, 11) == 0) ? '0 : BTN_W'($urandom_range(1, 7));
    return code;
  endfunction

  // Mostly the next correct digit for whatever half the lock is in, with random content;
  // the rest is wrong presses, chatter and quiet stretches.
  task automatic random_action();
    int unsigned      pick;
    logic [BTN_W-1:0] digit;
    pick = $urandom_range(0, 99);
    if (mode_q == kcac_pkg::ST_ARMING) begin
      if (pick < 60) wait_armed();
      else press(BTN_W'($urandom_range(1, 7)), pick[0]);
    end else if (pick < 70) begin
      if (mode_q < kcac_pkg::ST_ARMED) begin
        digit = code_digit(disarm_code_cfg, int'(mode_q));
      end else begin
        digit = code_digit(armed_code_cfg, int'(mode_q) - int'(kcac_pkg::ST_ARMED));
      end
      press(hit_mask(digit), pick[0]);
    end else if (pick < 85) begin
      press(BTN_W'($urandom_range(1, 7)), pick[0]);
    end else if (pick < 95) begin
      repeat ($urandom_range(1, 6)) send_tick(BTN_W'($urandom));
    end else begin
      hold(ALL_UP, $urandom_range(1, 20));
    end
  endtask

  // Random code entry over a few register settings; the last phase runs without idling.
  task automatic test_random_entry();
    int unsigned phase_end;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      set_config(($urandom_range(0, 9) == 0) ? ARM_DELAY_W'($urandom_range(0, 200))
                                             : ARM_DELAY_W'($urandom_range(1, 12)),
                 ($urandom_range(0, 3) == 0) ? BLINK_W'($urandom_range(0, 255))
                                             : BLINK_W'($urandom_range(0, 6)),
                 random_code(), random_code());
      if (phase == RANDOM_PHASES - 1) begin
        sender_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      phase_end = ticks_sent + RANDOM_TICKS / RANDOM_PHASES;
      while (ticks_sent < phase_end) random_action();
    end
  endtask

  // ---------------------------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------------------------

  initial begin
    in_req.valid         <= 1'b0;
    in_req.button_sample <= ALL_UP;
    cfg_we               <= 1'b0;
    cfg_index            <= kcac_pkg::CFG_ARM_DELAY;
    cfg_wdata            <= '0;
    rst_n                <= 1'b0;
    model_reset();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_debounce_edges();
    test_disarm_entry();
    test_armed_entry();
    test_zero_codes();
    test_arm_delay_extremes();
    test_random_entry();

    // Every request has its result once the queue is empty; a few more cycles catch any
    // result the block might still put out on its own.
    settle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* keypad_code_alarm_controller_unit.f */
design/kcac_pkg.sv
design/kcac_if.sv
design/kcac_debounce.sv
design/kcac_core.sv
design/keypad_code_alarm_controller_unit.sv
bench/keypad_code_alarm_controller_unit_tb.sv
